// ----- rtl/core/ecdc_pkg.sv -----
package ecdc_pkg;

	// Operation codes
	localparam logic [2:0] OP_REQUEST   = 3'd0;
	localparam logic [2:0] OP_MOVE      = 3'd1;
	localparam logic [2:0] OP_ARRIVE    = 3'd2;
	localparam logic [2:0] OP_OVERLOAD  = 3'd3;
	localparam logic [2:0] OP_EMERGENCY = 3'd4;
	localparam logic [2:0] OP_SET_MODE  = 3'd5;

	// Car modes
	localparam logic [2:0] MODE_STOP      = 3'd0;
	localparam logic [2:0] MODE_UP        = 3'd1;
	localparam logic [2:0] MODE_DOWN      = 3'd2;
	localparam logic [2:0] MODE_OPEN      = 3'd3;
	localparam logic [2:0] MODE_CLOSING   = 3'd4;
	localparam logic [2:0] MODE_OVERLOAD  = 3'd5;
	localparam logic [2:0] MODE_EMERGENCY = 3'd6;

	// Travel direction
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_EMPTY = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAX_WEIGHT  = 2'd0;
	localparam logic [1:0] CFG_START_FLOOR = 2'd1;
	localparam logic [1:0] CFG_START_MODE  = 2'd2;

	localparam int WEIGHT_W = 14;
	localparam int MODE_W   = 3;
	localparam int OP_W     = 3;
	localparam logic [WEIGHT_W-1:0] MAX_WEIGHT_RESET = 14'd1000;

	// Commands to the destination list
	typedef enum logic [1:0] {
		LK_INSERT,
		LK_REMOVE,
		LK_LOAD
	} list_kind_t;

	typedef struct packed {
		logic       start;
		list_kind_t kind;
		logic       desc;
	} list_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} list_stat_t;

endpackage

// ----- rtl/core/elevator_car_destination_controller_core.sv -----
// Elevator car controller with a sorted destination list.
// Input stream (s_*): one item per operation (request floor, move step, arrive,
// overload check, emergency, set mode). Output stream (m_*): exactly one
// status item per input item, in order.
// Config port: cfg_we/cfg_index/cfg_data write max_weight, start_floor and
// start_mode; floor and mode writes load the car state at once. Write only
// while the block is idle.
// Operations that do not touch the list go from accept straight to T_FIN and
// the output register. Arrive with removal, emergency and a floor request on
// a list that is not full wait in T_WAIT until the list sequencer is done. The
// insert walks the list down from the top, reading and shifting up each entry
// larger than the new floor through the single-port destination memory.
// s_tready is high only while no item is in work; one finished item may wait
// in the output register while the next one is accepted and processed. If
// m_tready stays low, the block finishes that next item and then holds it.
// Reset: empty list, floor 1, mode stop, direction none, max_weight 1000.
module elevator_car_destination_controller_core
	import ecdc_pkg::*;
#(
	parameter int DEST_DEPTH = 16,
	parameter int FLOOR_BITS = 8,
	localparam int CntW = $clog2(DEST_DEPTH + 1),
	localparam int CfgW = (FLOOR_BITS > WEIGHT_W) ? FLOOR_BITS : WEIGHT_W,
	localparam int InBits = OP_W + FLOOR_BITS + WEIGHT_W + MODE_W,
	localparam int InW = ((InBits + 7) / 8) * 8,
	localparam int OutBits = 2 * FLOOR_BITS + MODE_W + 7 + CntW,
	localparam int OutW = ((OutBits + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	input  logic            s_tvalid,
	output logic            s_tready,
	// operation, target_floor, load_weight, new_mode
	input  logic [InW-1:0]  s_tdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	// floor, car_mode, travel_dir, at_destination, pending, overload, error,
	// head_floor, request_count
	output logic [OutW-1:0] m_tdata
);

	localparam logic [FLOOR_BITS-1:0] FloorReset = FLOOR_BITS'(1);

	typedef enum logic [1:0] {
		T_IDLE,
		T_WAIT,
		T_FIN
	} tstate_t;

	tstate_t               state_q;
	logic [WEIGHT_W-1:0]   max_weight_q;
	logic [FLOOR_BITS-1:0] floor_q;
	logic [MODE_W-1:0]     mode_q;
	logic [1:0]            dir_q;
	logic [1:0]            err_q;
	logic                  ovl_q;
	logic                  atd_q;
	logic                  atd_taken_q;
	logic                  out_valid_q;
	logic [OutBits-1:0]    out_data_q;

	logic [OP_W-1:0]       op_in;
	logic [FLOOR_BITS-1:0] tf_in;
	logic [WEIGHT_W-1:0]   load_in;
	logic [MODE_W-1:0]     nm_in;
	logic                  accept;

	list_cmd_t             list_cmd;
	list_stat_t            list_stat;
	logic [FLOOR_BITS-1:0] list_head;
	logic [CntW-1:0]       list_count;
	logic                  nonempty;
	logic                  full;
	logic                  tf_above;
	logic                  head_gt;
	logic                  head_ne;
	logic [FLOOR_BITS-1:0] floor_mv;
	logic                  arrive_mv;
	logic [FLOOR_BITS-1:0] head_out;
	logic                  atd_out;
	logic                  pend_out;

	// Input unpacking
	assign op_in = s_tdata[OP_W-1:0];
	assign tf_in = s_tdata[OP_W +: FLOOR_BITS];
	assign load_in = s_tdata[OP_W + FLOOR_BITS +: WEIGHT_W];
	assign nm_in = s_tdata[OP_W + FLOOR_BITS + WEIGHT_W +: MODE_W];

	assign s_tready = (state_q == T_IDLE);
	assign accept = s_tvalid && s_tready;

	assign nonempty = (list_count != '0);
	assign full = (list_count >= CntW'(DEST_DEPTH));
	assign tf_above = tf_in > floor_q;

	// Move step: one floor toward the head
	assign head_gt = list_head > floor_q;
	assign head_ne = list_head != floor_q;
	assign floor_mv = !head_ne ? floor_q
		: (head_gt ? floor_q + FLOOR_BITS'(1) : floor_q - FLOOR_BITS'(1));
	assign arrive_mv = (list_head == floor_mv);

	// List command issue
	always_comb begin
		list_cmd.start = 1'b0;
		list_cmd.kind = LK_INSERT;
		list_cmd.desc = !tf_above;
		if (accept) begin
			unique case (op_in)
				OP_REQUEST: list_cmd.start = !full;
				OP_ARRIVE: begin
					list_cmd.kind = LK_REMOVE;
					list_cmd.start = nonempty && !head_ne;
				end
				OP_EMERGENCY: begin
					list_cmd.kind = LK_LOAD;
					list_cmd.start = 1'b1;
				end
				default: ;
			endcase
		end
	end

	ecdc_list #(
		.DEST_DEPTH(DEST_DEPTH),
		.FLOOR_BITS(FLOOR_BITS)
	) u_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (list_cmd),
		.floor_in(tf_in),
		.stat    (list_stat),
		.head    (list_head),
		.count   (list_count)
	);

	// Status fields after the operation
	assign head_out = nonempty ? list_head : '0;
	assign atd_out = atd_taken_q ? atd_q : (nonempty && !head_ne);
	assign pend_out = nonempty && head_ne;

	// Operation control, car state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			max_weight_q <= MAX_WEIGHT_RESET;
			floor_q <= FloorReset;
			mode_q <= MODE_STOP;
			dir_q <= DIR_NONE;
			err_q <= ERR_NONE;
			ovl_q <= 1'b0;
			atd_q <= 1'b0;
			atd_taken_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_WEIGHT: max_weight_q <= cfg_data[WEIGHT_W-1:0];
					CFG_START_FLOOR: floor_q <= cfg_data[FLOOR_BITS-1:0];
					CFG_START_MODE: begin
						mode_q <= (cfg_data[MODE_W-1:0] == MODE_W'(7)) ? MODE_STOP
							: cfg_data[MODE_W-1:0];
					end
					default: ;
				endcase
			end

			// T_FIN either reloads the register or keeps it held
			if (out_valid_q && m_tready && state_q != T_FIN) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						err_q <= ERR_NONE;
						ovl_q <= 1'b0;
						atd_q <= 1'b0;
						atd_taken_q <= 1'b0;
						state_q <= list_cmd.start ? T_WAIT : T_FIN;
						case (op_in)
							OP_REQUEST: begin
								if (full) begin
									err_q <= ERR_FULL;
								end else begin
									dir_q <= tf_above ? DIR_UP : DIR_DOWN;
								end
							end
							OP_MOVE: begin
								if (!nonempty) begin
									err_q <= ERR_EMPTY;
								end else begin
									floor_q <= floor_mv;
									if (head_ne) begin
										dir_q <= head_gt ? DIR_UP : DIR_DOWN;
									end
									if (mode_q != MODE_EMERGENCY) begin
										mode_q <= arrive_mv ? MODE_STOP
											: (head_gt ? MODE_UP : MODE_DOWN);
									end
								end
							end
							OP_ARRIVE: begin
								atd_taken_q <= 1'b1;
								atd_q <= nonempty && !head_ne;
								if (!nonempty) begin
									dir_q <= DIR_NONE;
								end
							end
							OP_OVERLOAD: begin
								if (load_in > max_weight_q) begin
									mode_q <= MODE_OVERLOAD;
									ovl_q <= 1'b1;
								end else begin
									mode_q <= MODE_OPEN;
								end
							end
							OP_EMERGENCY: mode_q <= MODE_EMERGENCY;
							OP_SET_MODE: begin
								if (nm_in != MODE_W'(7)) begin
									mode_q <= nm_in;
								end
							end
							default: ;
						endcase
					end
				end
				T_WAIT: begin
					if (list_stat.done) begin
						state_q <= T_FIN;
					end
				end
				T_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_data_q <= {list_count, head_out, err_q, ovl_q, pend_out,
							atd_out, dir_q, mode_q, floor_q};
						out_valid_q <= 1'b1;
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = OutW'(out_data_q);

`ifndef SYNTHESIS
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while previous item still in work");

	a_list_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !list_stat.busy)
		else $error("destination list busy while input is ready");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		list_stat.done |-> (state_q == T_WAIT))
		else $error("list finished with no operation waiting");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		list_count <= CntW'(DEST_DEPTH))
		else $error("destination list count beyond depth");
`endif

endmodule

// ----- rtl/core/ecdc_list.sv -----
module ecdc_list
	import ecdc_pkg::*;
#(
	parameter int DEST_DEPTH = 16,
	parameter int FLOOR_BITS = 8,
	localparam int CntW = $clog2(DEST_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  list_cmd_t             cmd,
	input  logic [FLOOR_BITS-1:0] floor_in,
	output list_stat_t            stat,
	output logic [FLOOR_BITS-1:0] head,
	output logic [CntW-1:0]       count
);

	localparam int IdxW = (DEST_DEPTH > 1) ? $clog2(DEST_DEPTH) : 1;
	localparam int SumW = IdxW + 1;

	typedef enum logic [2:0] {
		L_IDLE,
		L_RD,
		L_CMP,
		L_PUT,
		L_FETCH,
		L_DONE
	} lstate_t;

	lstate_t               state_q;
	logic [IdxW-1:0]       base_q;
	logic [CntW-1:0]       cnt_q;
	logic [CntW-1:0]       k_q;
	logic                  desc_q;
	logic [FLOOR_BITS-1:0] f_q;
	logic [FLOOR_BITS-1:0] rd_q;
	logic [FLOOR_BITS-1:0] mem [DEST_DEPTH];

	logic [IdxW-1:0]       k_sel;
	logic [SumW-1:0]       addr_sum;
	logic [IdxW-1:0]       addr;
	logic                  mem_we;
	logic                  mem_re;
	logic [FLOOR_BITS-1:0] mem_wdata;
	logic                  gt;
	logic [IdxW-1:0]       base_inc;

	// Entries are kept ascending in a ring starting at base_q; desc_q only
	// selects which end is the head.
	assign gt = rd_q > f_q;
	assign base_inc = (base_q == IdxW'(DEST_DEPTH - 1)) ? '0 : base_q + IdxW'(1);

	// Shared ring address adder
	assign addr_sum = {1'b0, base_q} + {1'b0, k_sel};
	assign addr = (addr_sum >= SumW'(DEST_DEPTH)) ? IdxW'(addr_sum - SumW'(DEST_DEPTH))
		: addr_sum[IdxW-1:0];

	// Memory access per step
	always_comb begin
		k_sel = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wdata = f_q;
		unique case (state_q)
			L_RD: begin
				k_sel = IdxW'(k_q - CntW'(1));
				mem_re = 1'b1;
			end
			L_CMP: begin
				k_sel = IdxW'(k_q);
				mem_we = 1'b1;
				mem_wdata = gt ? rd_q : f_q;
			end
			L_PUT: begin
				mem_we = 1'b1;
			end
			L_FETCH: begin
				k_sel = (desc_q && cnt_q != '0) ? IdxW'(cnt_q - CntW'(1)) : '0;
				mem_re = 1'b1;
			end
			default: ;
		endcase
	end

	// Destination memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[addr];
		end
	end

	// Sequencer: insert walks down from the top, shifting larger entries up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			base_q <= '0;
			cnt_q <= '0;
			k_q <= '0;
			desc_q <= 1'b0;
			f_q <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (cmd.start) begin
						f_q <= floor_in;
						unique case (cmd.kind)
							LK_INSERT: begin
								desc_q <= cmd.desc;
								k_q <= cnt_q;
								cnt_q <= cnt_q + CntW'(1);
								state_q <= (cnt_q == '0) ? L_PUT : L_RD;
							end
							LK_REMOVE: begin
								cnt_q <= cnt_q - CntW'(1);
								if (!desc_q) begin
									base_q <= base_inc;
								end
								state_q <= L_FETCH;
							end
							LK_LOAD: begin
								base_q <= '0;
								cnt_q <= CntW'(1);
								state_q <= L_PUT;
							end
							default: state_q <= L_IDLE;
						endcase
					end
				end
				L_RD: state_q <= L_CMP;
				L_CMP: begin
					if (gt) begin
						k_q <= k_q - CntW'(1);
						state_q <= (k_q == CntW'(1)) ? L_PUT : L_RD;
					end else begin
						state_q <= L_FETCH;
					end
				end
				L_PUT: state_q <= L_FETCH;
				L_FETCH: state_q <= L_DONE;
				L_DONE: state_q <= L_IDLE;
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != L_IDLE);
	assign stat.done = (state_q == L_DONE);
	assign head = rd_q;
	assign count = cnt_q;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import ecdc_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int QUIET_LIMIT = 1000;
	localparam int MAX_REPORTS = 100;

	// Input item, operation in the low bits
	typedef struct packed {
		logic [MODE_W-1:0]   new_mode;
		logic [WEIGHT_W-1:0] load_weight;
		logic [7:0]          target_floor;
		logic [OP_W-1:0]     operation;
	} car_cmd_t;

	// Status item, floor in the low bits
	typedef struct packed {
		logic [4:0]        request_count;
		logic [7:0]        head_floor;
		logic [1:0]        error;
		logic              overload;
		logic              pending;
		logic              at_destination;
		logic [1:0]        travel_dir;
		logic [MODE_W-1:0] car_mode;
		logic [7:0]        floor;
	} car_status_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [13:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	elevator_car_destination_controller_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Shadow copy of the car
	logic [7:0]          dest_floors [LIST_DEPTH];
	int                  dest_n;
	logic [7:0]          cur_floor;
	logic [MODE_W-1:0]   cur_mode;
	logic [1:0]          cur_dir;
	logic [WEIGHT_W-1:0] weight_limit;

	car_status_t car_status_q[$];
	int          fails;
	int          quiet_cycles;
	bit          tx_idle_on;
	bit          rx_idle_on;
	int          rx_hold;

	always #5 clk = ~clk;

	// Compute the status of one operation and update the shadow car
	function automatic car_status_t advance_car(car_cmd_t c);
		car_status_t s;
		logic [7:0]  t;
		logic        atd;
		bit          atd_done;
		int          i;
		int          j;
		s = '0;
		atd = 1'b0;
		atd_done = 0;
		case (c.operation)
			OP_REQUEST: begin
				if (dest_n >= LIST_DEPTH) begin
					s.error = ERR_FULL;
				end else begin
					dest_floors[dest_n] = c.target_floor;
					dest_n++;
					// whole list re-sorted ascending
					for (i = 1; i < dest_n; i++) begin
						t = dest_floors[i];
						j = i;
						while (j > 0 && dest_floors[j-1] > t) begin
							dest_floors[j] = dest_floors[j-1];
							j--;
						end
						dest_floors[j] = t;
					end
					if (c.target_floor > cur_floor) begin
						cur_dir = DIR_UP;
					end else begin
						cur_dir = DIR_DOWN;
						i = 0;
						j = dest_n - 1;
						while (i < j) begin
							t = dest_floors[i];
							dest_floors[i] = dest_floors[j];
							dest_floors[j] = t;
							i++;
							j--;
						end
					end
				end
			end
			OP_MOVE: begin
				if (dest_n == 0) begin
					s.error = ERR_EMPTY;
				end else begin
					if (dest_floors[0] > cur_floor) begin
						if (cur_mode != MODE_EMERGENCY) cur_mode = MODE_UP;
						cur_dir = DIR_UP;
						cur_floor = cur_floor + 8'd1;
					end else if (dest_floors[0] < cur_floor) begin
						if (cur_mode != MODE_EMERGENCY) cur_mode = MODE_DOWN;
						cur_dir = DIR_DOWN;
						cur_floor = cur_floor - 8'd1;
					end
					if (dest_floors[0] == cur_floor && cur_mode != MODE_EMERGENCY)
						cur_mode = MODE_STOP;
				end
			end
			OP_ARRIVE: begin
				// at_destination is taken before the head is dropped
				atd_done = 1;
				if (dest_n == 0) begin
					cur_dir = DIR_NONE;
				end else if (dest_floors[0] == cur_floor) begin
					atd = 1'b1;
					for (i = 1; i < dest_n; i++) dest_floors[i-1] = dest_floors[i];
					dest_n--;
				end
			end
			OP_OVERLOAD: begin
				if (c.load_weight > weight_limit) begin
					cur_mode = MODE_OVERLOAD;
					s.overload = 1'b1;
				end else begin
					cur_mode = MODE_OPEN;
				end
			end
			OP_EMERGENCY: begin
				dest_floors[0] = c.target_floor;
				dest_n = 1;
				cur_mode = MODE_EMERGENCY;
			end
			OP_SET_MODE: begin
				if (c.new_mode <= MODE_EMERGENCY) cur_mode = c.new_mode;
			end
			default: begin
			end
		endcase
		s.head_floor = (dest_n > 0) ? dest_floors[0] : 8'd0;
		if (!atd_done) atd = (dest_n > 0 && s.head_floor == cur_floor);
		s.floor = cur_floor;
		s.car_mode = cur_mode;
		s.travel_dir = cur_dir;
		s.at_destination = atd;
		s.pending = (dest_n > 0 && s.head_floor != cur_floor);
		s.request_count = dest_n[4:0];
		return s;
	endfunction

	// Send one item, optionally after an idle burst
	task automatic send_cmd(car_cmd_t c);
		int gap;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, c};
		do @(posedge clk); while (!s_tready);
		car_status_q.push_back(advance_car(c));
	endtask

	task automatic send_op(logic [2:0] op, logic [7:0] tf, logic [13:0] load,
		logic [2:0] nm);
		car_cmd_t c;
		c.operation = op;
		c.target_floor = tf;
		c.load_weight = load;
		c.new_mode = nm;
		send_cmd(c);
	endtask

	// Stop sending and wait until every status item is back
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (car_status_q.size() != 0) @(posedge clk);
	endtask

	// Register write; block must be idle
	task automatic write_reg(logic [1:0] idx, logic [13:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_MAX_WEIGHT: weight_limit = val;
			CFG_START_FLOOR: cur_floor = val[7:0];
			CFG_START_MODE: cur_mode = (val[2:0] <= MODE_EMERGENCY) ? val[2:0] : MODE_STOP;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic cmp_field(string name, int unsigned exp, int unsigned act);
		if (exp != act) begin
			fails++;
			if (fails <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, exp, act);
		end
	endtask

	// Check each status item against the oldest prediction
	always @(posedge clk) begin
		car_status_t got;
		car_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[30:0];
			if (car_status_q.size() == 0) begin
				fails++;
				if (fails <= MAX_REPORTS)
					$display("%0t: unexpected item expected none actual %h", $time, m_tdata);
			end else begin
				want = car_status_q.pop_front();
				cmp_field("floor", want.floor, got.floor);
				cmp_field("car_mode", want.car_mode, got.car_mode);
				cmp_field("travel_dir", want.travel_dir, got.travel_dir);
				cmp_field("at_destination", want.at_destination, got.at_destination);
				cmp_field("pending", want.pending, got.pending);
				cmp_field("overload", want.overload, got.overload);
				cmp_field("error", want.error, got.error);
				cmp_field("head_floor", want.head_floor, got.head_floor);
				cmp_field("request_count", want.request_count, got.request_count);
				cmp_field("pad", 0, m_tdata[31]);
			end
		end
	end

	// Receiver stalls in bursts
	always @(negedge clk) begin
		if (!rx_idle_on) begin
			m_tready <= 1'b1;
			rx_hold = 0;
		end else if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rx_hold = $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Edge cases from reset: empty list, modes, undefined ops, overload limit, emergency, requests
	task automatic test_directed();
		tx_idle_on = 1;
		rx_idle_on = 1;
		send_op(OP_ARRIVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_MOVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_SET_MODE, 8'd0, 14'd0, 3'd7);
		send_op(OP_SET_MODE, 8'd0, 14'd0, MODE_EMERGENCY);
		send_op(3'd6, 8'd255, 14'h3FFF, 3'd7);
		send_op(3'd7, 8'd255, 14'h3FFF, 3'd7);
		send_op(OP_OVERLOAD, 8'd0, 14'h3FFF, 3'd0);
		send_op(OP_OVERLOAD, 8'd0, 14'd1000, 3'd0);
		send_op(OP_OVERLOAD, 8'd0, 14'd1001, 3'd0);
		send_op(OP_EMERGENCY, 8'd0, 14'd0, 3'd0);
		send_op(OP_MOVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_ARRIVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_SET_MODE, 8'd0, 14'd0, MODE_STOP);
		send_op(OP_REQUEST, 8'd3, 14'd0, 3'd0);
		send_op(OP_REQUEST, 8'd0, 14'd0, 3'd0);
		send_op(OP_MOVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_ARRIVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_REQUEST, 8'd1, 14'd0, 3'd0);
		send_op(OP_ARRIVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_EMERGENCY, 8'd255, 14'd0, 3'd0);
		send_op(OP_MOVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_SET_MODE, 8'd0, 14'd0, MODE_CLOSING);
	endtask

	// Fill the list to the top, then one request too many, an arrive, a request and a move
	task automatic test_full_list();
		int k;
		k = 0;
		while (dest_n < LIST_DEPTH) begin
			send_op(OP_REQUEST, (k % 3 == 0) ? 8'd255 : 8'($urandom_range(2, 250)),
				14'd0, 3'd0);
			k++;
		end
		send_op(OP_REQUEST, 8'd0, 14'd0, 3'd0);
		send_op(OP_ARRIVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_REQUEST, 8'd0, 14'd0, 3'd0);
		send_op(OP_MOVE, 8'd0, 14'd0, 3'd0);
		settle();
	endtask

	// Register extremes, including start mode seven
	task automatic test_config_extremes();
		write_reg(CFG_MAX_WEIGHT, 14'd0);
		write_reg(CFG_START_FLOOR, 14'd255);
		write_reg(CFG_START_MODE, 14'd7);
		send_op(OP_OVERLOAD, 8'd0, 14'd0, 3'd0);
		send_op(OP_OVERLOAD, 8'd0, 14'd1, 3'd0);
		send_op(OP_MOVE, 8'd0, 14'd0, 3'd0);
		settle();
		write_reg(CFG_MAX_WEIGHT, 14'h3FFF);
		write_reg(CFG_START_FLOOR, 14'd0);
		write_reg(CFG_START_MODE, 14'(MODE_EMERGENCY));
		send_op(OP_OVERLOAD, 8'd0, 14'h3FFF, 3'd0);
		send_op(OP_SET_MODE, 8'd0, 14'd0, MODE_EMERGENCY);
		send_op(OP_MOVE, 8'd0, 14'd0, 3'd0);
		send_op(OP_ARRIVE, 8'd0, 14'd0, 3'd0);
		settle();
	endtask

	// Rides: mostly requests and moves toward nearby floors, plus noise
	task automatic test_random_traffic(int n_items, bit idle_on);
		car_cmd_t c;
		int       roll;
		int       req_pct;
		int       near;
		tx_idle_on = idle_on;
		rx_idle_on = idle_on;
		repeat (n_items) begin
			c.load_weight = $urandom_range(0, 1) ?
				14'($urandom_range(0, 16383)) :
				14'(weight_limit + $urandom_range(0, 4) - 2);
			c.new_mode = MODE_W'($urandom_range(0, 7));
			near = int'(cur_floor) + $urandom_range(0, 16) - 8;
			if (near < 0) near = 0;
			if (near > 255) near = 255;
			c.target_floor = ($urandom_range(0, 9) < 7) ? 8'(near) : 8'($urandom_range(0, 255));
			req_pct = (dest_n == 0) ? 55 : ((dest_n >= 12) ? 10 : 35);
			roll = $urandom_range(0, 99);
			if (roll < req_pct)
				c.operation = OP_REQUEST;
			else if (roll < 70)
				c.operation = (dest_n > 0 && dest_floors[0] == cur_floor &&
					$urandom_range(0, 4) != 0) ? OP_ARRIVE : OP_MOVE;
			else if (roll < 82)
				c.operation = OP_ARRIVE;
			else if (roll < 88)
				c.operation = OP_OVERLOAD;
			else if (roll < 91)
				c.operation = OP_EMERGENCY;
			else if (roll < 96)
				c.operation = OP_SET_MODE;
			else
				c.operation = OP_W'($urandom_range(6, 7));
			send_cmd(c);
		end
		settle();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		fails = 0;
		quiet_cycles = 0;
		tx_idle_on = 0;
		rx_idle_on = 0;
		rx_hold = 0;
		dest_n = 0;
		cur_floor = 8'd1;
		cur_mode = MODE_STOP;
		cur_dir = DIR_NONE;
		weight_limit = MAX_WEIGHT_RESET;
		foreach (dest_floors[i]) dest_floors[i] = 8'd0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_list();
		test_config_extremes();
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(CFG_MAX_WEIGHT, 14'($urandom_range(0, 16383)));
			write_reg(CFG_START_FLOOR, 14'($urandom_range(0, 255)));
			write_reg(CFG_START_MODE, 14'($urandom_range(0, 7)));
			test_random_traffic(200, $urandom_range(0, 3) != 0);
		end
		test_random_traffic(200, 0);

		settle();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
